// ----- hw/rtl/afr_pkg.sv -----
// shared layout mode type and codes for the aspect-fit rectangle calculator
`default_nettype none

package afr_pkg;

	// layout mode codes
	typedef enum logic [1:0] {
		FUNC_STRETCH  = 2'd0,
		FUNC_NO_SCALE = 2'd1,
		FUNC_CROP     = 2'd2,
		FUNC_FILL     = 2'd3
	} func_e_t;

endpackage

`default_nettype wire

// ----- hw/rtl/afr_div_stage.sv -----
// one registered restoring-division step: one quotient bit per stage
`default_nettype none

module afr_div_stage #(
	parameter int W = 16
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [2*W-1:0] work_i,
	input  wire logic [W-1:0]   den_i,
	output logic      [2*W-1:0] work_o,
	output logic      [W-1:0]   den_o
);

	// work holds {partial remainder, dividend bits left / quotient bits so far}
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_next;

	always_comb begin
		trial    = {work_i[2*W-1:W], work_i[W-1]};
		diff     = trial - {1'b0, den_i};
		ge       = (trial >= {1'b0, den_i});
		rem_next = ge ? diff[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_o <= {rem_next, work_i[W-2:0], ge};
			den_o  <= den_i;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/aspect_fit_rect_calc_core.sv -----
// top level of the aspect-fit rectangle calculator pipeline
`default_nettype none

// Usage:
// - input channel (in_valid/in_ready) carries one layout item: mode func plus
//   source and destination rectangles; output channel (out_valid/out_ready)
//   returns the source region to read, the destination region to draw and
//   bad_size, exactly one result per item, in order
// - stretch passes both rectangles; no-scale centers the smaller size in both;
//   crop trims the source to the destination aspect; fill letterboxes the
//   destination to the source aspect; sizes are exact quotients rounded half up
// - throughput: one item per cycle, sustained, whenever out_ready stays high
// - an item passes the input, cross-product, select and multiply stages,
//   then the divider, which resolves one quotient bit per stage, then the
//   round and output stages
// - reset clears all stage valid bits; no item is in flight afterwards
// - the whole pipeline holds while the output register is full and out_ready
//   is low; in_ready then drops in the same cycle, nothing is lost or repeated
module aspect_fit_rect_calc_core
	import afr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            func,
	input  wire logic [COORD_BITS-1:0] src_x,
	input  wire logic [COORD_BITS-1:0] src_y,
	input  wire logic [COORD_BITS-1:0] src_w,
	input  wire logic [COORD_BITS-1:0] src_h,
	input  wire logic [COORD_BITS-1:0] dst_x,
	input  wire logic [COORD_BITS-1:0] dst_y,
	input  wire logic [COORD_BITS-1:0] dst_w,
	input  wire logic [COORD_BITS-1:0] dst_h,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [COORD_BITS-1:0] out_src_x,
	output logic      [COORD_BITS-1:0] out_src_y,
	output logic      [COORD_BITS-1:0] out_src_w,
	output logic      [COORD_BITS-1:0] out_src_h,
	output logic      [COORD_BITS-1:0] out_dst_x,
	output logic      [COORD_BITS-1:0] out_dst_y,
	output logic      [COORD_BITS-1:0] out_dst_w,
	output logic      [COORD_BITS-1:0] out_dst_h,
	output logic                       bad_size
);

	localparam int N  = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;

	// item context that rides along the pipeline
	typedef struct packed {
		func_e_t      func;
		logic [N-1:0] sx;
		logic [N-1:0] sy;
		logic [N-1:0] sw;
		logic [N-1:0] sh;
		logic [N-1:0] dx;
		logic [N-1:0] dy;
		logic [N-1:0] dw;
		logic [N-1:0] dh;
		logic         bad;    // ratio mode with a zero size
		logic         calc_h; // divider result is the height, else the width
		logic [N-1:0] mw;     // no-scale used width
		logic [N-1:0] mh;     // no-scale used height
	} pay_t;

	// global advance: the output register is the only place an item can wait
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------------------------------------------------------- stage 1
	// capture the item
	logic vld_s1;
	pay_t pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1.func   <= func_e_t'(func);
			pay_s1.sx     <= src_x;
			pay_s1.sy     <= src_y;
			pay_s1.sw     <= src_w;
			pay_s1.sh     <= src_h;
			pay_s1.dx     <= dst_x;
			pay_s1.dy     <= dst_y;
			pay_s1.dw     <= dst_w;
			pay_s1.dh     <= dst_h;
			pay_s1.bad    <= 1'b0;
			pay_s1.calc_h <= 1'b0;
			pay_s1.mw     <= '0;
			pay_s1.mh     <= '0;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// aspect cross products and zero-size check
	logic          vld_s2;
	pay_t          pay_s2;
	logic [PW-1:0] cpa_s2; // dst_w * src_h
	logic [PW-1:0] cpb_s2; // src_w * dst_h
	logic          ratio_s1;
	logic          zero_s1;
	pay_t          nxt_pay2;

	always_comb begin
		ratio_s1 = (pay_s1.func == FUNC_CROP) || (pay_s1.func == FUNC_FILL);
		zero_s1  = (pay_s1.sw == '0) || (pay_s1.sh == '0) ||
		           (pay_s1.dw == '0) || (pay_s1.dh == '0);
		nxt_pay2     = pay_s1;
		nxt_pay2.bad = ratio_s1 && zero_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s2 <= nxt_pay2;
			cpa_s2 <= PW'(pay_s1.dw) * PW'(pay_s1.sh);
			cpb_s2 <= PW'(pay_s1.sw) * PW'(pay_s1.dh);
		end
	end

	// ---------------------------------------------------------------- stage 3
	// aspect compare picks the kept side and the operands of the quotient;
	// no-scale minimums are taken here too
	logic         vld_s3;
	pay_t         pay_s3;
	logic [N-1:0] a_s3;
	logic [N-1:0] b_s3;
	logic [N-1:0] d_s3;
	logic [N-1:0] sel_a;
	logic [N-1:0] sel_b;
	logic [N-1:0] sel_d;
	logic         sel_h;
	logic         gt_s2;
	logic         lt_s2;
	pay_t         nxt_pay3;

	always_comb begin
		gt_s2 = cpa_s2 > cpb_s2;
		lt_s2 = cpa_s2 < cpb_s2;
		// harmless operands for items that skip the divider
		sel_a = '0;
		sel_b = '0;
		sel_d = N'(1);
		sel_h = 1'b0;
		if (!pay_s2.bad) begin
			case (pay_s2.func)
				FUNC_CROP: begin
					if (gt_s2) begin
						// keep source width, trim height
						sel_a = pay_s2.sw;
						sel_b = pay_s2.dh;
						sel_d = pay_s2.dw;
						sel_h = 1'b1;
					end else begin
						sel_a = pay_s2.sh;
						sel_b = pay_s2.dw;
						sel_d = pay_s2.dh;
						sel_h = 1'b0;
					end
				end
				FUNC_FILL: begin
					if (lt_s2) begin
						// keep destination width, letterbox height
						sel_a = pay_s2.dw;
						sel_b = pay_s2.sh;
						sel_d = pay_s2.sw;
						sel_h = 1'b1;
					end else begin
						sel_a = pay_s2.dh;
						sel_b = pay_s2.sw;
						sel_d = pay_s2.sh;
						sel_h = 1'b0;
					end
				end
				default: ;
			endcase
		end
		nxt_pay3        = pay_s2;
		nxt_pay3.calc_h = sel_h;
		nxt_pay3.mw     = (pay_s2.sw < pay_s2.dw) ? pay_s2.sw : pay_s2.dw;
		nxt_pay3.mh     = (pay_s2.sh < pay_s2.dh) ? pay_s2.sh : pay_s2.dh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s3 <= nxt_pay3;
			a_s3   <= sel_a;
			b_s3   <= sel_b;
			d_s3   <= sel_d;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// dividend product
	logic          vld_s4;
	pay_t          pay_s4;
	logic [PW-1:0] p_s4;
	logic [N-1:0]  d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s4 <= pay_s3;
			p_s4   <= PW'(a_s3) * PW'(b_s3);
			d_s4   <= d_s3;
		end
	end

	// ---------------------------------------------------------- divider chain
	// the quotient never exceeds the size it replaces, so the upper half of the
	// product is already below the divisor: N steps give the full quotient
	logic          vld_sd [0:N];
	pay_t          pay_sd [0:N];
	logic [PW-1:0] work_sd [0:N];
	logic [N-1:0]  den_sd [0:N];

	assign vld_sd[0]  = vld_s4;
	assign pay_sd[0]  = pay_s4;
	assign work_sd[0] = p_s4;
	assign den_sd[0]  = d_s4;

	for (genvar k = 0; k < N; k++) begin : g_div
		afr_div_stage #(
			.W(N)
		) u_div (
			.clk    (clk),
			.en     (en),
			.work_i (work_sd[k]),
			.den_i  (den_sd[k]),
			.work_o (work_sd[k+1]),
			.den_o  (den_sd[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_sd[k+1] <= pay_sd[k];
			end
		end
	end

	// ---------------------------------------------------------------- stage 5
	// round half up: bump the quotient when twice the remainder reaches d
	logic         vld_s5;
	pay_t         pay_s5;
	logic [N-1:0] used_s5;
	logic [N-1:0] quo;
	logic [N-1:0] rem;
	logic         half_up;

	always_comb begin
		quo     = work_sd[N][N-1:0];
		rem     = work_sd[N][PW-1:N];
		half_up = {rem, 1'b0} >= {1'b0, den_sd[N]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_sd[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s5  <= pay_sd[N];
			used_s5 <= quo + N'(half_up);
		end
	end

	// ---------------------------------------------------------------- stage 6
	// final sizes and centering; this is the output register
	logic [N-1:0] n_sx;
	logic [N-1:0] n_sy;
	logic [N-1:0] n_sw;
	logic [N-1:0] n_sh;
	logic [N-1:0] n_dx;
	logic [N-1:0] n_dy;
	logic [N-1:0] n_dw;
	logic [N-1:0] n_dh;

	always_comb begin
		n_sx = pay_s5.sx;
		n_sy = pay_s5.sy;
		n_sw = pay_s5.sw;
		n_sh = pay_s5.sh;
		n_dx = pay_s5.dx;
		n_dy = pay_s5.dy;
		n_dw = pay_s5.dw;
		n_dh = pay_s5.dh;
		case (pay_s5.func)
			FUNC_NO_SCALE: begin
				n_sw = pay_s5.mw;
				n_sh = pay_s5.mh;
				n_dw = pay_s5.mw;
				n_dh = pay_s5.mh;
				n_sx = pay_s5.sx + ((pay_s5.sw - pay_s5.mw) >> 1);
				n_sy = pay_s5.sy + ((pay_s5.sh - pay_s5.mh) >> 1);
				n_dx = pay_s5.dx + ((pay_s5.dw - pay_s5.mw) >> 1);
				n_dy = pay_s5.dy + ((pay_s5.dh - pay_s5.mh) >> 1);
			end
			FUNC_CROP: begin
				if (!pay_s5.bad) begin
					if (pay_s5.calc_h) begin
						n_sh = used_s5;
					end else begin
						n_sw = used_s5;
					end
					n_sx = pay_s5.sx + ((pay_s5.sw - n_sw) >> 1);
					n_sy = pay_s5.sy + ((pay_s5.sh - n_sh) >> 1);
				end
			end
			FUNC_FILL: begin
				if (!pay_s5.bad) begin
					if (pay_s5.calc_h) begin
						n_dh = used_s5;
					end else begin
						n_dw = used_s5;
					end
					n_dx = pay_s5.dx + ((pay_s5.dw - n_dw) >> 1);
					n_dy = pay_s5.dy + ((pay_s5.dh - n_dh) >> 1);
				end
			end
			default: ;
		endcase
	end

	logic vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_src_x <= n_sx;
			out_src_y <= n_sy;
			out_src_w <= n_sw;
			out_src_h <= n_sh;
			out_dst_x <= n_dx;
			out_dst_y <= n_dy;
			out_dst_w <= n_dw;
			out_dst_h <= n_dh;
			bad_size  <= pay_s5.bad;
		end
	end

	assign out_valid = vld_s6;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the aspect-fit rectangle calculator: directed and random items
module tb;
	import afr_pkg::*;

	localparam int CB = 16;
	// accepting edge to out_valid, as counted from the core's stages
	localparam int PIPE_LATENCY = CB + 5;
	// far above the slowest correct run of about a thousand items with stalls
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CB-1:0] CMAX = '1;

	// one layout request, field order as on the input ports
	typedef struct packed {
		func_e_t       func;
		logic [CB-1:0] src_x;
		logic [CB-1:0] src_y;
		logic [CB-1:0] src_w;
		logic [CB-1:0] src_h;
		logic [CB-1:0] dst_x;
		logic [CB-1:0] dst_y;
		logic [CB-1:0] dst_w;
		logic [CB-1:0] dst_h;
	} layout_req_t;

	// one fitted layout, field order as on the output ports
	typedef struct packed {
		logic [CB-1:0] src_x;
		logic [CB-1:0] src_y;
		logic [CB-1:0] src_w;
		logic [CB-1:0] src_h;
		logic [CB-1:0] dst_x;
		logic [CB-1:0] dst_y;
		logic [CB-1:0] dst_w;
		logic [CB-1:0] dst_h;
		logic          bad_size;
	} layout_res_t;

	// fitted layouts predicted for accepted requests, checked in order
	class fit_scoreboard;
		layout_res_t pending_layouts[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned bad_seen;
		int unsigned mode_seen[4];

		// a*b/d rounded half up
		function logic [63:0] half_up_quotient(logic [63:0] a, logic [63:0] b,
				logic [63:0] d);
			logic [63:0] p;
			logic [63:0] q;
			p = a * b;
			q = p / d;
			if (2 * (p % d) >= d)
				q = q + 1;
			return q;
		endfunction

		// offset by half the unused size, wrapping at the coordinate width
		function logic [CB-1:0] centered(logic [63:0] pos, logic [63:0] full,
				logic [63:0] used);
			logic [63:0] s;
			s = pos + (full - used) / 2;
			return s[CB-1:0];
		endfunction

		function layout_res_t fit_rects(layout_req_t r);
			logic [63:0] sw, sh, dw, dh, mw, mh, qv;
			layout_res_t o;
			sw = 64'(r.src_w);
			sh = 64'(r.src_h);
			dw = 64'(r.dst_w);
			dh = 64'(r.dst_h);
			o = '{r.src_x, r.src_y, r.src_w, r.src_h, r.dst_x, r.dst_y, r.dst_w, r.dst_h, 1'b0};
			case (r.func)
				FUNC_NO_SCALE: begin
					mw = (sw < dw) ? sw : dw;
					mh = (sh < dh) ? sh : dh;
					o.src_w = mw[CB-1:0];
					o.src_h = mh[CB-1:0];
					o.dst_w = mw[CB-1:0];
					o.dst_h = mh[CB-1:0];
					o.src_x = centered(64'(r.src_x), sw, mw);
					o.src_y = centered(64'(r.src_y), sh, mh);
					o.dst_x = centered(64'(r.dst_x), dw, mw);
					o.dst_y = centered(64'(r.dst_y), dh, mh);
				end
				FUNC_CROP, FUNC_FILL: begin
					if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
						o.bad_size = 1'b1;
					end else if (r.func == FUNC_CROP) begin
						// equal aspects keep the source height
						if (dw * sh > sw * dh) begin
							qv = half_up_quotient(sw, dh, dw);
							o.src_h = qv[CB-1:0];
						end else begin
							qv = half_up_quotient(sh, dw, dh);
							o.src_w = qv[CB-1:0];
						end
						o.src_x = centered(64'(r.src_x), sw, 64'(o.src_w));
						o.src_y = centered(64'(r.src_y), sh, 64'(o.src_h));
					end else begin
						// equal aspects keep the destination height
						if (dw * sh < sw * dh) begin
							qv = half_up_quotient(dw, sh, sw);
							o.dst_h = qv[CB-1:0];
						end else begin
							qv = half_up_quotient(dh, sw, sh);
							o.dst_w = qv[CB-1:0];
						end
						o.dst_x = centered(64'(r.dst_x), dw, 64'(o.dst_w));
						o.dst_y = centered(64'(r.dst_y), dh, 64'(o.dst_h));
					end
				end
				default: begin
				end
			endcase
			return o;
		endfunction

		function void note_request(layout_req_t r);
			layout_res_t e;
			e = fit_rects(r);
			pending_layouts.push_back(e);
			mode_seen[r.func]++;
			if (e.bad_size)
				bad_seen++;
		endfunction

		function void compare_field(string name, logic [CB-1:0] e, logic [CB-1:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
				mismatches++;
			end
		endfunction

		function void check_layout(layout_res_t act);
			layout_res_t e;
			if (pending_layouts.size() == 0) begin
				$display("%0t: result with no request waiting, expected none actual %h",
					$time, act);
				mismatches++;
				return;
			end
			e = pending_layouts.pop_front();
			checked++;
			compare_field("out_src_x", e.src_x, act.src_x);
			compare_field("out_src_y", e.src_y, act.src_y);
			compare_field("out_src_w", e.src_w, act.src_w);
			compare_field("out_src_h", e.src_h, act.src_h);
			compare_field("out_dst_x", e.dst_x, act.dst_x);
			compare_field("out_dst_y", e.dst_y, act.dst_y);
			compare_field("out_dst_w", e.dst_w, act.dst_w);
			compare_field("out_dst_h", e.dst_h, act.dst_h);
			compare_field("bad_size", CB'(e.bad_size), CB'(act.bad_size));
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [1:0]    func = '0;
	logic [CB-1:0] src_x = '0;
	logic [CB-1:0] src_y = '0;
	logic [CB-1:0] src_w = '0;
	logic [CB-1:0] src_h = '0;
	logic [CB-1:0] dst_x = '0;
	logic [CB-1:0] dst_y = '0;
	logic [CB-1:0] dst_w = '0;
	logic [CB-1:0] dst_h = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [CB-1:0] out_src_x;
	logic [CB-1:0] out_src_y;
	logic [CB-1:0] out_src_w;
	logic [CB-1:0] out_src_h;
	logic [CB-1:0] out_dst_x;
	logic [CB-1:0] out_dst_y;
	logic [CB-1:0] out_dst_w;
	logic [CB-1:0] out_dst_h;
	logic          bad_size;

	layout_res_t   seen_layout;
	fit_scoreboard sb;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   cycle_count = 0;

	aspect_fit_rect_calc_core #(
		.COORD_BITS(CB)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.src_x    (src_x),
		.src_y    (src_y),
		.src_w    (src_w),
		.src_h    (src_h),
		.dst_x    (dst_x),
		.dst_y    (dst_y),
		.dst_w    (dst_w),
		.dst_h    (dst_h),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_src_x(out_src_x),
		.out_src_y(out_src_y),
		.out_src_w(out_src_w),
		.out_src_h(out_src_h),
		.out_dst_x(out_dst_x),
		.out_dst_y(out_dst_y),
		.out_dst_w(out_dst_w),
		.out_dst_h(out_dst_h),
		.bad_size (bad_size)
	);

	// result ports gathered in the scoreboard's field order
	assign seen_layout = {out_src_x, out_src_y, out_src_w, out_src_h,
		out_dst_x, out_dst_y, out_dst_w, out_dst_h, bad_size};

	initial begin
		forever #1 clk = ~clk;
	end

	// run limit: a hung handshake ends here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	// receiver: outputs are read before this edge's updates land,
	// then out_ready is redrawn for the next cycle
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_layout(seen_layout);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic layout_req_t make_req(func_e_t f,
			logic [CB-1:0] sx, logic [CB-1:0] sy, logic [CB-1:0] sw, logic [CB-1:0] sh,
			logic [CB-1:0] dx, logic [CB-1:0] dy, logic [CB-1:0] dw, logic [CB-1:0] dh);
		layout_req_t r;
		r = '{f, sx, sy, sw, sh, dx, dy, dw, dh};
		return r;
	endfunction

	// sizes lean toward zero, one, tiny and near-maximum values
	function automatic logic [CB-1:0] random_size();
		logic [CB-1:0] v;
		case ($urandom_range(19))
			0: v = '0;
			1, 2: v = CMAX;
			3: v = 1;
			4, 5, 6: v = CB'($urandom_range(16, 1));
			7, 8: v = CB'($urandom_range(CMAX, CMAX - 16));
			9, 10: v = CB'($urandom_range(4096, 1));
			default: v = CB'($urandom);
		endcase
		return v;
	endfunction

	// coordinates near the top make the centering offset wrap
	function automatic logic [CB-1:0] random_coord();
		logic [CB-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1, 2: v = CB'($urandom_range(CMAX, CMAX - 255));
			default: v = CB'($urandom);
		endcase
		return v;
	endfunction

	function automatic layout_req_t random_request();
		layout_req_t r;
		int unsigned k;
		int unsigned m;
		k = $urandom_range(9);
		if (k == 0)
			r.func = FUNC_STRETCH;
		else if (k == 1)
			r.func = FUNC_NO_SCALE;
		else if (k < 6)
			r.func = FUNC_CROP;
		else
			r.func = FUNC_FILL;
		r.src_x = random_coord();
		r.src_y = random_coord();
		r.dst_x = random_coord();
		r.dst_y = random_coord();
		if ($urandom_range(99) < 15) begin
			// one rectangle a whole multiple of the other: equal aspects
			r.src_w = CB'($urandom_range(255, 1));
			r.src_h = CB'($urandom_range(255, 1));
			m = $urandom_range(250, 1);
			r.dst_w = CB'(r.src_w * m);
			r.dst_h = CB'(r.src_h * m);
			if ($urandom_range(1)) begin
				{r.src_w, r.dst_w} = {r.dst_w, r.src_w};
				{r.src_h, r.dst_h} = {r.dst_h, r.src_h};
			end
		end else begin
			r.src_w = random_size();
			r.src_h = random_size();
			r.dst_w = random_size();
			r.dst_h = random_size();
		end
		return r;
	endfunction

	// present one item, with random idle cycles ahead of it, and hold it until taken
	task automatic drive_item(layout_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= r.func;
		src_x    <= r.src_x;
		src_y    <= r.src_y;
		src_w    <= r.src_w;
		src_h    <= r.src_h;
		dst_x    <= r.dst_x;
		dst_y    <= r.dst_y;
		dst_w    <= r.dst_w;
		dst_h    <= r.dst_h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// sender holds off until every predicted layout has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_layouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			drive_item(random_request());
		wait_drained();
	endtask

	initial begin
		sb = new();
		// reset held low from the start, released once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each mode, ties, half-up rounding, zero sizes, wrap
		drive_item(make_req(FUNC_STRETCH, 0, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_req(FUNC_STRETCH, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		drive_item(make_req(FUNC_NO_SCALE, 10, 20, 100, 50, 5, 7, 640, 480));
		drive_item(make_req(FUNC_NO_SCALE, CMAX, CB'(CMAX - 1), 1920, 1080, CMAX, CMAX,
			641, 3));
		drive_item(make_req(FUNC_NO_SCALE, 3, 4, 0, 9, 1, 2, 7, 0));
		drive_item(make_req(FUNC_NO_SCALE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0));
		drive_item(make_req(FUNC_CROP, 100, 200, 640, 480, 0, 0, 1920, 1080));
		drive_item(make_req(FUNC_CROP, 100, 200, 1920, 1080, 0, 0, 480, 640));
		drive_item(make_req(FUNC_CROP, 1, 2, 320, 240, 3, 4, 640, 480));
		drive_item(make_req(FUNC_CROP, 0, 0, 1, 1, 0, 0, 2, 1));
		drive_item(make_req(FUNC_CROP, 0, 0, 1, 1, 0, 0, 1, 2));
		drive_item(make_req(FUNC_CROP, 5, 5, 0, 100, 6, 6, 100, 100));
		drive_item(make_req(FUNC_CROP, 5, 5, 100, 100, 6, 6, 100, 0));
		drive_item(make_req(FUNC_CROP, CMAX, CMAX, CMAX, 1, 0, 0, 1, CMAX));
		drive_item(make_req(FUNC_FILL, 0, 0, 1920, 1080, 10, 20, 640, 640));
		drive_item(make_req(FUNC_FILL, 0, 0, 480, 640, 10, 20, 1920, 1080));
		drive_item(make_req(FUNC_FILL, 9, 9, 640, 480, 1, 1, 320, 240));
		drive_item(make_req(FUNC_FILL, 0, 0, 2, 1, 0, 0, 1, 1));
		drive_item(make_req(FUNC_FILL, 0, 0, 1, 2, 0, 0, 1, 1));
		drive_item(make_req(FUNC_FILL, 1, 1, 100, 0, 2, 2, 50, 50));
		drive_item(make_req(FUNC_FILL, 1, 1, 100, 100, 2, 2, 0, 50));
		drive_item(make_req(FUNC_FILL, 0, 0, 1, CMAX, CMAX, CMAX, CMAX, 1));
		drive_item(make_req(FUNC_FILL, 0, 0, CMAX, CMAX, CMAX, CB'(CMAX - 2), CMAX, CMAX));
		wait_drained();

		// random phases: free running, sender gaps, receiver stalls, both
		run_phase(0, 0, 245);
		run_phase(54, 0, 245);
		run_phase(0, 54, 245);
		run_phase(21, 21, 245);

		// allow any stray result to show up after the last expected one
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		$display("checked %0d layouts (stretch %0d, no scale %0d, crop %0d, fill %0d)",
			sb.checked, sb.mode_seen[FUNC_STRETCH], sb.mode_seen[FUNC_NO_SCALE],
			sb.mode_seen[FUNC_CROP], sb.mode_seen[FUNC_FILL]);
		$display("%0d with bad size; idling phases: none, sender 54%%, receiver 54%%, %s",
			sb.bad_seen, "both 21%");
		if (sb.mismatches == 0 && sb.pending_layouts.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
